@@ src/pidaw_pkg.sv @@
// shared constants, types and saturation helper for the pid controller
`default_nettype none

package pidaw_pkg;

  localparam int DataWidth  = 32;
  localparam int FracBits   = 16;
  localparam int IntegWidth = 48;
  localparam int ProdWidth  = IntegWidth + DataWidth;
  localparam int MagWidth   = ProdWidth - FracBits;
  localparam int NumWidth   = DataWidth + 1;
  localparam int DivWidth   = NumWidth + FracBits;
  localparam int AddrWidth  = 5;

  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_BACKCALC_GAIN,
    REG_OUT_MIN,
    REG_OUT_MAX,
    REG_LIMIT_ENABLE,
    REG_WINDUP_MODE
  } reg_idx_e;

  typedef enum logic [1:0] {
    AW_NONE,
    AW_CALC,
    AW_COND,
    AW_FILT
  } windup_e;

  typedef struct packed {
    logic start;
    logic neg;
    logic wide;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // signed result from sign and magnitude, saturated to 48 or 32 bits
  function automatic logic signed [IntegWidth-1:0] sat_mag(input logic neg,
                                                          input logic [MagWidth-1:0] m,
                                                          input logic wide);
    logic [MagWidth-1:0] lim;
    logic [MagWidth-1:0] mm;
    lim = wide ? (MagWidth'(1) << (IntegWidth - 1)) : (MagWidth'(1) << (DataWidth - 1));
    if (neg) begin
      mm = (m > lim) ? lim : m;
      mm = MagWidth'(0) - mm;
    end else begin
      mm = (m > lim - MagWidth'(1)) ? lim - MagWidth'(1) : m;
    end
    return mm[IntegWidth-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/pidaw_if.sv @@
// valid/ready channel interfaces for samples and controller outputs
`default_nettype none

interface pidaw_in_if import pidaw_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic        [DataWidth-1:0] time_step;
  logic signed [DataWidth-1:0] error_in;

  modport source (output valid, time_step, error_in, input ready);
  modport sink (input valid, time_step, error_in, output ready);
endinterface

interface pidaw_out_if import pidaw_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] drive;
  logic                        limited;

  modport source (output valid, drive, limited, input ready);
  modport sink (input valid, drive, limited, output ready);
endinterface

`default_nettype wire

@@ src/pidaw_mul.sv @@
// bit-serial shift-add fixed point multiplier with saturation
`default_nettype none

module pidaw_mul import pidaw_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire unit_req_t                    req_i,
  input  wire logic      [IntegWidth-1:0]   mcand_i,
  input  wire logic      [DataWidth-1:0]    mplier_i,
  output unit_sts_t                         sts_o,
  output logic signed    [IntegWidth-1:0]   res_o
);

  logic [ProdWidth:0]             p_q;
  logic [IntegWidth-1:0]          mc_q;
  logic                           neg_q;
  logic                           wide_q;
  logic [$clog2(DataWidth)-1:0]   cnt_q;
  logic                           busy_q;
  logic                           fin_q;
  logic [IntegWidth:0]            sum;

  assign sum = p_q[ProdWidth:DataWidth] + (p_q[0] ? {1'b0, mc_q} : (IntegWidth + 1)'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ($clog2(DataWidth))'(DataWidth - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      p_q    <= {(IntegWidth + 1)'(0), mplier_i};
      mc_q   <= mcand_i;
      neg_q  <= req_i.neg;
      wide_q <= req_i.wide;
    end else if (busy_q) begin
      p_q <= {1'b0, sum, p_q[DataWidth-1:1]};
    end
  end

  assign res_o      = sat_mag(neg_q, p_q[ProdWidth-1:FracBits], wide_q);
  assign sts_o.busy = busy_q;
  assign sts_o.done = fin_q;

endmodule

`default_nettype wire

@@ src/pidaw_div.sv @@
// restoring fixed point divider, one quotient bit per cycle, with saturation
`default_nettype none

module pidaw_div import pidaw_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire unit_req_t                    req_i,
  input  wire logic      [NumWidth-1:0]     num_i,
  input  wire logic      [DataWidth-1:0]    den_i,
  output unit_sts_t                         sts_o,
  output logic signed    [IntegWidth-1:0]   res_o
);

  logic [DivWidth-1:0]           dvd_q;
  logic [DataWidth-1:0]          rem_q;
  logic [DataWidth-1:0]          den_q;
  logic                          neg_q;
  logic                          wide_q;
  logic [$clog2(DivWidth)-1:0]   cnt_q;
  logic                          busy_q;
  logic                          fin_q;
  logic [DataWidth:0]            trial;
  logic [DataWidth:0]            diff;
  logic                          ge;

  assign trial = {rem_q, dvd_q[DivWidth-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ($clog2(DivWidth))'(DivWidth - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q  <= {num_i, FracBits'(0)};
      rem_q  <= '0;
      den_q  <= den_i;
      neg_q  <= req_i.neg;
      wide_q <= req_i.wide;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
      dvd_q <= {dvd_q[DivWidth-2:0], ge};
    end
  end

  assign res_o      = sat_mag(neg_q, MagWidth'(dvd_q), wide_q);
  assign sts_o.busy = busy_q;
  assign sts_o.done = fin_q;

endmodule

`default_nettype wire

@@ src/pid_controller_anti_windup.sv @@
// pid controller top level: register port, step sequencer and output register
//
// Samples (time_step, error_in) arrive on in_i, one controller output
// (drive, limited) leaves on out_o for each sample, both valid/ready
// channels; a transfer happens when valid and ready are both high.
// Gains, limits and the anti-windup mode are written over the APB-style
// port at byte address 4*index; the user must write them only while no
// sample is in flight, as the block itself does not enforce this. One
// shared shift-add multiplier and one restoring divider do all the
// arithmetic in turn, plus a divide in calculation anti-windup mode when
// limiting is on with a nonzero integral gain; a zero time step skips the arithmetic.
// in_i.ready is high only while the sequencer is idle. The finished result
// sits in an output register; a stalled receiver holds it there while the
// next sample is taken, and the sequencer waits at its end until it drains.
// Reset clears the controller state, loads the register defaults and
// empties the output register.
`default_nettype none

module pid_controller_anti_windup import pidaw_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [AddrWidth-1:0]   paddr,
  input  wire logic [DataWidth-1:0]   pwdata,
  output logic      [DataWidth-1:0]   prdata,
  output logic                        pready,
  pidaw_in_if.sink                    in_i,
  pidaw_out_if.source                 out_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BC,
    ST_INC,
    ST_DER,
    ST_PROP,
    ST_DGAIN,
    ST_IGAIN,
    ST_LIMIT,
    ST_AW,
    ST_DONE
  } state_e;

  localparam logic signed [DataWidth-1:0] MaxD = {1'b0, {(DataWidth - 1){1'b1}}};
  localparam logic signed [DataWidth-1:0] MinD = {1'b1, {(DataWidth - 1){1'b0}}};

  function automatic logic signed [DataWidth-1:0] sat_d(input logic signed [DataWidth:0] v);
    if (v[DataWidth] != v[DataWidth-1]) begin
      return v[DataWidth] ? MinD : MaxD;
    end
    return v[DataWidth-1:0];
  endfunction

  function automatic logic signed [IntegWidth-1:0] sat_i(
      input logic signed [IntegWidth:0] v);
    if (v[IntegWidth] != v[IntegWidth-1]) begin
      return v[IntegWidth] ? {1'b1, {(IntegWidth - 1){1'b0}}}
                           : {1'b0, {(IntegWidth - 1){1'b1}}};
    end
    return v[IntegWidth-1:0];
  endfunction

  function automatic logic signed [DataWidth:0] ext_d(input logic signed [DataWidth-1:0] v);
    return {v[DataWidth-1], v};
  endfunction

  function automatic logic [DataWidth-1:0] mag_d(input logic signed [DataWidth-1:0] v);
    return v[DataWidth-1] ? DataWidth'(-v) : v;
  endfunction

  function automatic logic [IntegWidth-1:0] mag_i(input logic signed [IntegWidth-1:0] v);
    return v[IntegWidth-1] ? IntegWidth'(-v) : v;
  endfunction

  function automatic logic [NumWidth-1:0] mag_n(input logic signed [NumWidth-1:0] v);
    return v[NumWidth-1] ? NumWidth'(-v) : v;
  endfunction

  function automatic logic signed [DataWidth-1:0] clampv(input logic signed [DataWidth-1:0] v,
                                                       input logic signed [DataWidth-1:0] mn,
                                                       input logic signed [DataWidth-1:0] mx);
    if (v < mn) begin
      return mn;
    end
    if (v > mx) begin
      return mx;
    end
    return v;
  endfunction

  state_e                        state_q;
  logic                          issued_q;

  logic signed [DataWidth-1:0]   kp_q, ki_q, kd_q, kb_q, min_q, max_q;
  logic                          len_q;
  windup_e                       mode_q;

  logic        [DataWidth-1:0]   dt_q;
  logic signed [DataWidth-1:0]   e_q;
  logic signed [IntegWidth-1:0]  integ_q;
  logic signed [IntegWidth-1:0]  old_int_q;
  logic signed [DataWidth-1:0]   prev_q;
  logic signed [DataWidth-1:0]   excess_q;
  logic signed [DataWidth-1:0]   held_q;
  logic signed [DataWidth-1:0]   tmp_q;
  logic signed [DataWidth-1:0]   d_q;
  logic signed [DataWidth-1:0]   pd_q;
  logic signed [DataWidth-1:0]   value_q;
  logic signed [NumWidth-1:0]    awnum_q;
  logic                          lim_q;

  logic                          out_valid_q;
  logic signed [DataWidth-1:0]   drive_q;
  logic                          limited_q;

  unit_req_t                     mul_req, div_req;
  unit_sts_t                     mul_sts, div_sts;
  logic        [IntegWidth-1:0]  mcand;
  logic        [DataWidth-1:0]   mplier;
  logic        [NumWidth-1:0]    num;
  logic        [DataWidth-1:0]   den;
  logic signed [IntegWidth-1:0]  mul_res, div_res;
  logic signed [NumWidth-1:0]    err_diff;
  logic signed [DataWidth-1:0]   clamped;
  logic                          cfg_wr;

  assign err_diff = ext_d(e_q) - ext_d(prev_q);
  assign clamped  = clampv(value_q, min_q, max_q);
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    mul_req = '0;
    div_req = '0;
    mcand   = '0;
    mplier  = '0;
    num     = '0;
    den     = '0;
    case (state_q)
      ST_BC: begin
        mul_req.start = !issued_q;
        mul_req.neg   = kb_q[DataWidth-1] ^ excess_q[DataWidth-1];
        mcand         = IntegWidth'(mag_d(excess_q));
        mplier        = mag_d(kb_q);
      end
      ST_INC: begin
        mul_req.start = !issued_q;
        mul_req.neg   = tmp_q[DataWidth-1];
        mul_req.wide  = 1'b1;
        mcand         = IntegWidth'(mag_d(tmp_q));
        mplier        = dt_q;
      end
      ST_DER: begin
        div_req.start = !issued_q;
        div_req.neg   = err_diff[NumWidth-1];
        num           = mag_n(err_diff);
        den           = dt_q;
      end
      ST_PROP: begin
        mul_req.start = !issued_q;
        mul_req.neg   = kp_q[DataWidth-1] ^ e_q[DataWidth-1];
        mcand         = IntegWidth'(mag_d(e_q));
        mplier        = mag_d(kp_q);
      end
      ST_DGAIN: begin
        mul_req.start = !issued_q;
        mul_req.neg   = kd_q[DataWidth-1] ^ d_q[DataWidth-1];
        mcand         = IntegWidth'(mag_d(d_q));
        mplier        = mag_d(kd_q);
      end
      ST_IGAIN: begin
        mul_req.start = !issued_q;
        mul_req.neg   = ki_q[DataWidth-1] ^ integ_q[IntegWidth-1];
        mcand         = mag_i(integ_q);
        mplier        = mag_d(ki_q);
      end
      ST_AW: begin
        div_req.start = !issued_q;
        div_req.neg   = awnum_q[NumWidth-1] ^ ki_q[DataWidth-1];
        div_req.wide  = 1'b1;
        num           = mag_n(awnum_q);
        den           = mag_d(ki_q);
      end
      default: begin
      end
    endcase
  end

  pidaw_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mul_req),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .sts_o    (mul_sts),
    .res_o    (mul_res)
  );

  pidaw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (num),
    .den_i  (den),
    .sts_o  (div_sts),
    .res_o  (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      kb_q        <= '0;
      min_q       <= MinD;
      max_q       <= MaxD;
      len_q       <= 1'b0;
      mode_q      <= AW_NONE;
      dt_q        <= '0;
      e_q         <= '0;
      integ_q     <= '0;
      old_int_q   <= '0;
      prev_q      <= '0;
      excess_q    <= '0;
      held_q      <= '0;
      tmp_q       <= '0;
      d_q         <= '0;
      pd_q        <= '0;
      value_q     <= '0;
      awnum_q     <= '0;
      lim_q       <= 1'b0;
      out_valid_q <= 1'b0;
      drive_q     <= '0;
      limited_q   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_e'(paddr[AddrWidth-1:2]))
          REG_PROP_GAIN:     kp_q   <= pwdata;
          REG_INTEG_GAIN:    ki_q   <= pwdata;
          REG_DERIV_GAIN:    kd_q   <= pwdata;
          REG_BACKCALC_GAIN: kb_q   <= pwdata;
          REG_OUT_MIN:       min_q  <= pwdata;
          REG_OUT_MAX:       max_q  <= pwdata;
          REG_LIMIT_ENABLE:  len_q  <= pwdata[0];
          REG_WINDUP_MODE:   mode_q <= windup_e'(pwdata[1:0]);
          default: begin
          end
        endcase
      end

      if (out_valid_q && out_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      if (mul_req.start || div_req.start) begin
        issued_q <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            dt_q     <= in_i.time_step;
            e_q      <= in_i.error_in;
            lim_q    <= 1'b0;
            issued_q <= 1'b0;
            state_q  <= (in_i.time_step == '0) ? ST_DONE : ST_BC;
          end
        end
        ST_BC: begin
          if (mul_sts.done) begin
            tmp_q    <= sat_d(ext_d(e_q) - ext_d(mul_res[DataWidth-1:0]));
            issued_q <= 1'b0;
            state_q  <= ST_INC;
          end
        end
        ST_INC: begin
          if (mul_sts.done) begin
            old_int_q <= integ_q;
            integ_q   <= sat_i({integ_q[IntegWidth-1], integ_q}
                               + {mul_res[IntegWidth-1], mul_res});
            issued_q  <= 1'b0;
            state_q   <= ST_DER;
          end
        end
        ST_DER: begin
          if (div_sts.done) begin
            d_q      <= div_res[DataWidth-1:0];
            prev_q   <= e_q;
            issued_q <= 1'b0;
            state_q  <= ST_PROP;
          end
        end
        ST_PROP: begin
          if (mul_sts.done) begin
            tmp_q    <= mul_res[DataWidth-1:0];
            issued_q <= 1'b0;
            state_q  <= ST_DGAIN;
          end
        end
        ST_DGAIN: begin
          if (mul_sts.done) begin
            pd_q     <= sat_d(ext_d(tmp_q) + ext_d(mul_res[DataWidth-1:0]));
            issued_q <= 1'b0;
            state_q  <= ST_IGAIN;
          end
        end
        ST_IGAIN: begin
          if (mul_sts.done) begin
            value_q  <= sat_d(ext_d(pd_q) + ext_d(mul_res[DataWidth-1:0]));
            issued_q <= 1'b0;
            state_q  <= ST_LIMIT;
          end
        end
        ST_LIMIT: begin
          state_q <= ST_DONE;
          if (len_q) begin
            held_q <= clamped;
            lim_q  <= clamped != value_q;
            case (mode_q)
              AW_CALC: begin
                if (ki_q != '0) begin
                  awnum_q <= ext_d(clamped) - ext_d(clampv(pd_q, min_q, max_q));
                  state_q <= ST_AW;
                end
              end
              AW_COND: begin
                if (clamped != value_q) begin
                  integ_q <= old_int_q;
                end
              end
              AW_FILT: begin
                excess_q <= sat_d(ext_d(value_q) - ext_d(clamped));
              end
              default: begin
              end
            endcase
          end else begin
            held_q <= value_q;
          end
        end
        ST_AW: begin
          if (div_sts.done) begin
            integ_q  <= div_res;
            issued_q <= 1'b0;
            state_q  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            drive_q     <= held_q;
            limited_q   <= lim_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[AddrWidth-1:2]))
      REG_PROP_GAIN:     prdata = kp_q;
      REG_INTEG_GAIN:    prdata = ki_q;
      REG_DERIV_GAIN:    prdata = kd_q;
      REG_BACKCALC_GAIN: prdata = kb_q;
      REG_OUT_MIN:       prdata = min_q;
      REG_OUT_MAX:       prdata = max_q;
      REG_LIMIT_ENABLE:  prdata = DataWidth'(len_q);
      REG_WINDUP_MODE:   prdata = DataWidth'(mode_q);
      default:           prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign in_i.ready    = state_q == ST_IDLE;
  assign out_o.valid   = out_valid_q;
  assign out_o.drive   = drive_q;
  assign out_o.limited = limited_q;

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  a_drive_is_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> drive_q == held_q)
    else $error("new result does not match held output");

  a_limited_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && limited_q |-> len_q)
    else $error("limited flag without limiting enabled");

  a_no_start_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_sts.busy)
    else $error("multiplier restarted while busy");

endmodule

`default_nettype wire

@@ bench/pid_controller_anti_windup_tb.sv @@
// self-checking testbench for the pid controller: random and directed samples, scoreboarded
`default_nettype none

module pid_controller_anti_windup_tb;
  import pidaw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        [DataWidth-1:0] dt;
    logic signed [DataWidth-1:0] err;
  } sample_t;

  typedef struct {
    logic signed [DataWidth-1:0] drive;
    logic                        limited;
  } ctrl_out_t;

  logic                 clk;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  pidaw_in_if  in_ch ();
  pidaw_out_if out_ch ();

  pid_controller_anti_windup uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sample_t   samples_q[$];
  ctrl_out_t drive_exp_q[$];
  int        errors;
  logic      in_taken;
  logic      calm;
  logic      start_hold;
  int        hold_cnt;
  int        quiet_cycles;

  // controller model state and registers
  longint   kp, ki, kd, kb, omin, omax;
  logic     lim_en;
  windup_e  aw_mode;
  longint   integ_acc, last_err, excess_acc, held_drive;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [127:0] magn(longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint sat_w(logic neg, logic [127:0] m, int w);
    logic [127:0] lim;
    lim = 128'(1) << (w - 1);
    if (neg) begin
      if (m > lim) m = lim;
      return -longint'(m[63:0]);
    end
    if (m > lim - 1) m = lim - 1;
    return longint'(m[63:0]);
  endfunction

  function automatic longint clip(longint v, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint mul_q(longint a, longint b, int w);
    return sat_w((a < 0) != (b < 0), (magn(a) * magn(b)) >> FracBits, w);
  endfunction

  function automatic longint div_q(longint n, longint d, int w);
    return sat_w((n < 0) != (d < 0), (magn(n) << FracBits) / magn(d), w);
  endfunction

  function automatic longint limit_to(longint v);
    if (v < omin) return omin;
    if (v > omax) return omax;
    return v;
  endfunction

  function automatic ctrl_out_t step_controller(sample_t s);
    ctrl_out_t r;
    longint dt, e, old_i, t, inc, d, pd, value;
    dt = longint'({32'b0, s.dt});
    e = longint'(s.err);
    r.limited = 1'b0;
    if (dt != 0) begin
      old_i = integ_acc;
      t = clip(e - mul_q(kb, excess_acc, DataWidth), DataWidth);
      inc = mul_q(t, dt, IntegWidth);
      d = div_q(e - last_err, dt, DataWidth);
      integ_acc = clip(integ_acc + inc, IntegWidth);
      last_err = e;
      pd = clip(mul_q(kp, e, DataWidth) + mul_q(kd, d, DataWidth), DataWidth);
      value = clip(pd + mul_q(ki, integ_acc, DataWidth), DataWidth);
      if (lim_en) begin
        held_drive = limit_to(value);
        r.limited = held_drive != value;
        case (aw_mode)
          AW_CALC: if (ki != 0) integ_acc = div_q(held_drive - limit_to(pd), ki, IntegWidth);
          AW_COND: if (r.limited) integ_acc = old_i;
          AW_FILT: excess_acc = clip(value - held_drive, DataWidth);
          default: ;
        endcase
      end else begin
        held_drive = value;
      end
    end
    r.drive = held_drive[DataWidth-1:0];
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [DataWidth-1:0] val);
    longint s;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrWidth'(idx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    s = longint'($signed(val));
    case (idx)
      REG_PROP_GAIN:     kp = s;
      REG_INTEG_GAIN:    ki = s;
      REG_DERIV_GAIN:    kd = s;
      REG_BACKCALC_GAIN: kb = s;
      REG_OUT_MIN:       omin = s;
      REG_OUT_MAX:       omax = s;
      REG_LIMIT_ENABLE:  lim_en = val[0];
      REG_WINDUP_MODE:   aw_mode = windup_e'(val[1:0]);
      default: ;
    endcase
  endtask

  function automatic logic [DataWidth-1:0] rand_gain();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return $urandom();
    if (p < 12) return 32'h7fff_ffff;
    if (p < 16) return 32'h8000_0000;
    return 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) s.dt = '0;
    else if (p < 15) s.dt = 32'hffff_ffff;
    else if (p < 25) s.dt = $urandom();
    else s.dt = $urandom_range(1, 32'h2_0000);
    p = $urandom_range(0, 99);
    if (p < 5) s.err = 32'sh8000_0000;
    else if (p < 10) s.err = 32'sh7fff_ffff;
    else if (p < 30) s.err = $urandom();
    else s.err = 32'($urandom_range(0, 32'h10_0000)) - 32'h8_0000;
    return s;
  endfunction

  task automatic push_sample(logic [DataWidth-1:0] dt, logic [DataWidth-1:0] err);
    sample_t s;
    s.dt = dt;
    s.err = err;
    samples_q.push_back(s);
  endtask

  task automatic drain();
    wait (samples_q.size() == 0 && drive_exp_q.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  // sample driver
  always @(negedge clk) begin
    if (in_ch.valid && !in_taken) begin
      in_ch.valid <= 1'b1;
    end else if (samples_q.size() == 0 || (!calm && $urandom_range(0, 99) < 31)) begin
      in_ch.valid <= 1'b0;
    end else begin
      sample_t s;
      s = samples_q.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.time_step <= s.dt;
      in_ch.error_in <= s.err;
    end
  end

  // receiver ready, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (start_hold) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= 1500;
      start_hold <= 1'b0;
    end else begin
      out_ch.ready <= calm || $urandom_range(0, 99) >= 31;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer drive=%h limited=%b", $realtime,
                   out_ch.drive, out_ch.limited);
        end else begin
          ctrl_out_t x;
          x = drive_exp_q.pop_front();
          if (out_ch.drive !== x.drive) begin
            errors++;
            $display("%0t: drive expected %h actual %h", $realtime, x.drive, out_ch.drive);
          end
          if (out_ch.limited !== x.limited) begin
            errors++;
            $display("%0t: limited expected %b actual %b", $realtime, x.limited,
                     out_ch.limited);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        sample_t s;
        s.dt = in_ch.time_step;
        s.err = in_ch.error_in;
        drive_exp_q.push_back(step_controller(s));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [DataWidth-1:0] lo, hi;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.time_step = '0;
    in_ch.error_in = '0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    calm = 1'b0;
    start_hold = 1'b0;
    hold_cnt = 0;
    quiet_cycles = 0;
    errors = 0;
    kp = 0; ki = 0; kd = 0; kb = 0;
    omax = 64'sd2147483647;
    omin = -64'sd2147483648;
    lim_en = 1'b0;
    aw_mode = AW_NONE;
    integ_acc = 0; last_err = 0; excess_acc = 0; held_drive = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults: all gains zero
    push_sample(32'h0001_0000, 32'h0001_0000);
    push_sample(32'h0, 32'h7fff_ffff);
    drain();

    // directed: extreme gains, saturation, skipped steps, inverted limits
    write_reg(REG_PROP_GAIN, 32'h7fff_ffff);
    write_reg(REG_INTEG_GAIN, 32'h8000_0000);
    write_reg(REG_DERIV_GAIN, 32'h7fff_ffff);
    write_reg(REG_BACKCALC_GAIN, 32'h0001_0000);
    write_reg(REG_OUT_MIN, 32'hfff0_0000);
    write_reg(REG_OUT_MAX, 32'h0010_0000);
    write_reg(REG_LIMIT_ENABLE, 32'h1);
    write_reg(REG_WINDUP_MODE, 32'(AW_FILT));
    push_sample(32'hffff_ffff, 32'h7fff_ffff);
    push_sample(32'h0000_0001, 32'h8000_0000);
    push_sample(32'h0, 32'h1234_5678);
    push_sample(32'hffff_ffff, 32'h8000_0000);
    push_sample(32'h0000_0001, 32'h0);
    drain();
    write_reg(REG_WINDUP_MODE, 32'(AW_CALC));
    push_sample(32'h0001_0000, 32'h7fff_ffff);
    push_sample(32'h0000_8000, 32'h8000_0000);
    drain();
    write_reg(REG_INTEG_GAIN, 32'h0);
    push_sample(32'h0001_0000, 32'h0100_0000);
    push_sample(32'h0001_0000, 32'hff00_0000);
    drain();
    write_reg(REG_WINDUP_MODE, 32'(AW_COND));
    write_reg(REG_INTEG_GAIN, 32'h0000_8000);
    write_reg(REG_OUT_MIN, 32'h0010_0000);
    write_reg(REG_OUT_MAX, 32'hfff0_0000);
    push_sample(32'h0001_0000, 32'h0000_0001);
    push_sample(32'h0001_0000, 32'h7fff_0000);
    push_sample(32'h0001_0000, 32'h8001_0000);
    push_sample(32'h0, 32'h0);
    drain();
    write_reg(REG_LIMIT_ENABLE, 32'h0);
    push_sample(32'h0002_0000, 32'h7fff_ffff);
    push_sample(32'h0002_0000, 32'h8000_0000);
    drain();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph == 5);
      write_reg(REG_PROP_GAIN, rand_gain());
      write_reg(REG_INTEG_GAIN, (ph == 7) ? 32'h0 : rand_gain());
      write_reg(REG_DERIV_GAIN, rand_gain());
      write_reg(REG_BACKCALC_GAIN, rand_gain());
      lo = 32'($urandom_range(0, 32'h20_0000)) - 32'h20_0000;
      hi = 32'($urandom_range(0, 32'h20_0000));
      if (ph == 9) begin
        write_reg(REG_OUT_MIN, hi);
        write_reg(REG_OUT_MAX, lo);
      end else if (ph == 10) begin
        write_reg(REG_OUT_MIN, 32'h8000_0000);
        write_reg(REG_OUT_MAX, 32'h7fff_ffff);
      end else begin
        write_reg(REG_OUT_MIN, lo);
        write_reg(REG_OUT_MAX, hi);
      end
      write_reg(REG_LIMIT_ENABLE, (ph % 6 == 4) ? 32'h0 : 32'h1);
      write_reg(REG_WINDUP_MODE, (ph == 7) ? 32'(AW_CALC) : 32'(ph % 4));
      for (int k = 0; k < 90; k++) samples_q.push_back(rand_sample());
      if (ph == 3) begin
        wait (drive_exp_q.size() > 0);
        start_hold = 1'b1;
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
